/* rtl/periodic_timer_table_unit_macros.svh */
// ---------------------------------------------------------------------------
// Periodic timer table assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TABLE_UNIT_MACROS_SVH
`define PERIODIC_TIMER_TABLE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("periodic timer table: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("periodic timer table: next-cycle check failed");

`endif

/* rtl/ptt_pkg.sv */
// ---------------------------------------------------------------------------
// Periodic timer table package
// Operation and result codes, sequencer states and the table entry layout.
// ---------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_CANCEL   = 2'd1,
    KIND_FIRED    = 2'd2,
    KIND_TICK_END = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ADD  = 2'd1,
    ST_SCAN = 2'd2,
    ST_FIN  = 2'd3
  } state_e;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] deadline;
    logic [31:0] period;
    logic        active;
    logic        periodic;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/periodic_timer_table_unit.sv */
// ---------------------------------------------------------------------------
// Periodic timer table unit
// Ordered table of one-shot and periodic timers with add, cancel and tick.
// ---------------------------------------------------------------------------
// The block takes one operation at a time. An add takes the transfer in
// idle, then writes the entry and posts the reply once the output register
// is free. A tick or a cancel walks the table, which sits in a memory with
// one read and one write port and a registered read: a small sequencer
// walks it one entry per cycle while no fired result is held by a stall
// on the result channel, reading entry i+1 while it judges entry i. A
// cancel stops at the first matching id. A tick writes each kept entry
// back to the next free slot as it goes, so compaction costs no extra pass.
// in_stall_o is high from the transfer of an item until its last result
// sits in the output register; that result may still wait there while the
// next item is taken. Op code 3 is dropped without a result.
// ---------------------------------------------------------------------------
`default_nettype none

module periodic_timer_table_unit
  import ptt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] deadline_i,
  input  wire logic        periodic_i,
  input  wire logic [31:0] period_i,
  input  wire logic [31:0] target_id_i,
  input  wire logic [31:0] now_time_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      timer_id_o,
  output logic             success_o,
  output logic             last_o
);

`include "periodic_timer_table_unit_macros.svh"

  // Count width holds the depth itself; address width indexes entries only.
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Sequencer and bookkeeping
  state_e        st_q, st_d;
  op_e           op_q;
  logic [31:0]   deadline_q, period_q, target_q, now_q;
  logic          periodic_q;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   id_q, id_d;
  logic [CW-1:0] scan_idx_q, scan_idx_d;
  logic [CW-1:0] ev_idx_q, ev_idx_d;
  logic          ev_vld_q, ev_vld_d;
  logic [CW-1:0] keep_q, keep_d;
  logic          found_q, found_d;

  // Table memory, one read and one write port
  entry_t        table_mem [TABLE_DEPTH];
  entry_t        rd_data_q;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  // Output register
  logic          out_valid_q;
  kind_e         kind_q;
  logic [31:0]   res_id_q;
  logic          res_ok_q, res_last_q;
  logic          push;
  kind_e         push_kind;
  logic [31:0]   push_id;
  logic          push_ok, push_last;

  logic in_accept, out_free, full, scan_end, fire, match, ev_done, issue;

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (count_q >= DEPTH_C);
  assign scan_end   = !ev_vld_q && ((scan_idx_q == count_q) || found_q);

  // Entry under judgement: fires on a tick, matches on a cancel.
  assign fire  = ev_vld_q && (op_q == OP_TICK) && rd_data_q.active &&
                 (rd_data_q.deadline <= now_q);
  assign match = ev_vld_q && (op_q == OP_CANCEL) && !found_q &&
                 (rd_data_q.id == target_q);
  // Hold the judged entry while a fired result cannot be posted.
  assign ev_done = !fire || out_free;
  assign issue   = (st_q == ST_SCAN) && (!ev_vld_q || ev_done) &&
                   (scan_idx_q < count_q) && !found_q && !match;

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (op_i)
            OP_ADD:              st_d = ST_ADD;
            OP_CANCEL, OP_TICK:  st_d = ST_SCAN;
            default:             st_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD:  if (out_free) st_d = ST_IDLE;
      ST_SCAN: if (scan_end) st_d = ST_FIN;
      ST_FIN:  if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory access, results, bookkeeping
  always_comb begin
    rd_en      = issue;
    wr_en      = 1'b0;
    wr_addr    = keep_q[AW-1:0];
    wr_data    = rd_data_q;
    push       = 1'b0;
    push_kind  = KIND_ADD;
    push_id    = 32'd0;
    push_ok    = 1'b0;
    push_last  = 1'b1;
    count_d    = count_q;
    id_d       = id_q;
    scan_idx_d = scan_idx_q;
    ev_idx_d   = ev_idx_q;
    ev_vld_d   = ev_vld_q;
    keep_d     = keep_q;
    found_d    = found_q;

    case (st_q)
      ST_IDLE: begin
        if (in_accept) begin
          scan_idx_d = '0;
          ev_vld_d   = 1'b0;
          keep_d     = '0;
          found_d    = 1'b0;
        end
      end

      ST_ADD: begin
        if (out_free) begin
          push      = 1'b1;
          push_kind = KIND_ADD;
          if (!full) begin
            // Append at the tail and hand out the next id.
            wr_en            = 1'b1;
            wr_addr          = count_q[AW-1:0];
            wr_data.id       = id_q;
            wr_data.deadline = deadline_q;
            wr_data.period   = period_q;
            wr_data.active   = 1'b1;
            wr_data.periodic = periodic_q;
            push_id          = id_q;
            push_ok          = 1'b1;
            count_d          = CW'(count_q + 1'b1);
            id_d             = id_q + 32'd1;
          end
        end
      end

      ST_SCAN: begin
        if (ev_vld_q && ev_done) begin
          if (op_q == OP_TICK) begin
            if (fire) begin
              push      = 1'b1;
              push_kind = KIND_FIRED;
              push_id   = rd_data_q.id;
              push_ok   = 1'b1;
              push_last = 1'b0;
            end
            // Keep the entry unless it is a fired one-shot; slide it down.
            if (!(fire && !rd_data_q.periodic)) begin
              wr_en   = 1'b1;
              wr_addr = keep_q[AW-1:0];
              if (fire) begin
                wr_data.deadline = rd_data_q.deadline + rd_data_q.period;
              end
              keep_d = CW'(keep_q + 1'b1);
            end
          end else if (match) begin
            wr_en          = 1'b1;
            wr_addr        = ev_idx_q[AW-1:0];
            wr_data.active = 1'b0;
            found_d        = 1'b1;
          end
        end
        if (issue) begin
          ev_vld_d   = 1'b1;
          ev_idx_d   = scan_idx_q;
          scan_idx_d = CW'(scan_idx_q + 1'b1);
        end else if (!ev_vld_q || ev_done) begin
          ev_vld_d = 1'b0;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          push = 1'b1;
          if (op_q == OP_TICK) begin
            push_kind = KIND_TICK_END;
            push_ok   = 1'b1;
            count_d   = keep_q;
          end else begin
            push_kind = KIND_CANCEL;
            push_ok   = found_q;
          end
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      count_q     <= '0;
      id_q        <= 32'd1;
      scan_idx_q  <= '0;
      ev_idx_q    <= '0;
      ev_vld_q    <= 1'b0;
      keep_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q       <= st_d;
      count_q    <= count_d;
      id_q       <= id_d;
      scan_idx_q <= scan_idx_d;
      ev_idx_q   <= ev_idx_d;
      ev_vld_q   <= ev_vld_d;
      keep_q     <= keep_d;
      found_q    <= found_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Captured operands and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q       <= op_e'(op_i);
      deadline_q <= deadline_i;
      periodic_q <= periodic_i;
      period_q   <= period_i;
      target_q   <= target_id_i;
      now_q      <= now_time_i;
    end
    if (push) begin
      kind_q     <= push_kind;
      res_id_q   <= push_id;
      res_ok_q   <= push_ok;
      res_last_q <= push_last;
    end
  end

  // Table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= table_mem[scan_idx_q[AW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign timer_id_o  = res_id_q;
  assign success_o   = res_ok_q;
  assign last_o      = res_last_q;

  // Table never holds more than its depth.
  `PTT_ASSERT_SAME(a_count_bound, 1'b1, count_q <= DEPTH_C)
  // Compaction writes never overtake the entry being judged.
  `PTT_ASSERT_SAME(a_keep_behind, (st_q == ST_SCAN) && ev_vld_q, keep_q <= ev_idx_q)
  // An accepted add uses exactly one id.
  `PTT_ASSERT_NEXT(a_id_step, (st_q == ST_ADD) && push && !full, id_q == $past(id_q) + 32'd1)
  // The closing result returns the sequencer to idle.
  `PTT_ASSERT_NEXT(a_fin_idle, (st_q == ST_FIN) && push, st_q == ST_IDLE)

endmodule

`default_nettype wire

/* sim/ptt_result_checker.sv */
// ---------------------------------------------------------------------------
// Periodic timer table result checker
// Watches both channels of the timer table, keeps its own copy of the table,
// works out the replies of every accepted request and compares each reply
// transfer against the oldest one still due.
// ---------------------------------------------------------------------------
module ptt_result_checker
  import ptt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] deadline_i,
  input  logic        periodic_i,
  input  logic [31:0] period_i,
  input  logic [31:0] target_id_i,
  input  logic [31:0] now_time_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] timer_id_i,
  input  logic        success_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] timer_id;
    logic        success;
    logic        last;
  } reply_t;

  reply_t      due_replies_q[$];
  entry_t      timers[TABLE_DEPTH];
  int unsigned timer_count;
  logic [31:0] next_id;
  int          errors = 0;

  // Append one due reply at the tail of the queue.
  task automatic push_reply(input kind_e k, input logic [31:0] id, input logic ok,
                            input logic fin);
    reply_t r;
    r = '{kind: k, timer_id: id, success: ok, last: fin};
    due_replies_q = {due_replies_q, r};
  endtask

  // Apply one accepted request to the table copy and queue its replies.
  task automatic advance_timer_table();
    int unsigned keep;
    logic        found;
    logic        drop;
    entry_t      e;
    case (op_i)
      OP_ADD: begin
        if (timer_count >= TABLE_DEPTH) begin
          push_reply(KIND_ADD, 32'd0, 1'b0, 1'b1);
        end else begin
          timers[timer_count] = '{id: next_id, deadline: deadline_i, period: period_i,
                                  active: 1'b1, periodic: periodic_i};
          timer_count++;
          push_reply(KIND_ADD, next_id, 1'b1, 1'b1);
          next_id++;
        end
      end
      OP_CANCEL: begin
        found = 1'b0;
        for (int i = 0; i < timer_count; i++) begin
          if (timers[i].id == target_id_i) begin
            timers[i].active = 1'b0;
            found = 1'b1;
            break;
          end
        end
        push_reply(KIND_CANCEL, 32'd0, found, 1'b1);
      end
      OP_TICK: begin
        keep = 0;
        for (int i = 0; i < timer_count; i++) begin
          e = timers[i];
          drop = 1'b0;
          if (e.active && e.deadline <= now_time_i) begin
            push_reply(KIND_FIRED, e.id, 1'b1, 1'b0);
            if (e.periodic) begin
              e.deadline = e.deadline + e.period;
            end else begin
              drop = 1'b1;
            end
          end
          if (!drop) begin
            timers[keep] = e;
            keep++;
          end
        end
        timer_count = keep;
        push_reply(KIND_TICK_END, 32'd0, 1'b1, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic check_reply();
    reply_t want;
    if (due_replies_q.size() == 0) begin
      $display("%0t: result expected none actual kind %0d id %0d success %0d last %0d",
               $time, kind_i, timer_id_i, success_i, last_i);
      errors++;
    end else begin
      want = due_replies_q.pop_front();
      if (kind_i !== want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind_i);
        errors++;
      end
      if (timer_id_i !== want.timer_id) begin
        $display("%0t: timer_id expected %0d actual %0d", $time, want.timer_id, timer_id_i);
        errors++;
      end
      if (success_i !== want.success) begin
        $display("%0t: success expected %0d actual %0d", $time, want.success, success_i);
        errors++;
      end
      if (last_i !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, last_i);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_replies_q.delete();
      timer_count = 0;
      next_id = 32'd1;
      pending_o <= 0;
      fail_count_o <= errors;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        advance_timer_table();
      end
      if (out_valid_i && !out_stall_i) begin
        check_reply();
      end
      pending_o <= due_replies_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

/* sim/tb_top.sv */
// ---------------------------------------------------------------------------
// Periodic timer table testbench
// Drives add, cancel and tick requests into the timer table, first a directed
// walk through the corner cases, then a random mix around a moving clock of
// seconds, with random idle and stall bursts on both channels. The checker
// beside the block predicts and compares every reply; this module gives the
// verdict.
// ---------------------------------------------------------------------------
module tb_top
  import ptt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TableDepth  = 32;
  localparam int          RandomItems = 130;
  localparam int          QuietItems  = 30;
  localparam int          DrainCycles = 40;
  localparam int          CycleLimit  = 400000;
  // Op code with no operation behind it; the block must drop it silently.
  localparam logic [1:0]  OpUnused    = 2'd3;
  localparam logic [31:0] AllOnes     = 32'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_ADD;
  logic [31:0] deadline = '0;
  logic        periodic = 1'b0;
  logic [31:0] period = '0;
  logic [31:0] target_id = '0;
  logic [31:0] now_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [31:0] timer_id;
  logic        success;
  logic        last;

  int          fail_count;
  int          pending;
  int          cycles = 0;
  logic        quiet = 1'b0;

  periodic_timer_table_unit #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .op_i       (op),
    .deadline_i (deadline),
    .periodic_i (periodic),
    .period_i   (period),
    .target_id_i(target_id),
    .now_time_i (now_time),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .kind_o     (kind),
    .timer_id_o (timer_id),
    .success_o  (success),
    .last_o     (last)
  );

  ptt_result_checker #(
    .TABLE_DEPTH(TableDepth)
  ) chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .op_i        (op),
    .deadline_i  (deadline),
    .periodic_i  (periodic),
    .period_i    (period),
    .target_id_i (target_id),
    .now_time_i  (now_time),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .kind_i      (kind),
    .timer_id_i  (timer_id),
    .success_i   (success),
    .last_i      (last),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #10 clk = ~clk;

  // Bound the run; a hung handshake ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: alternate random stall bursts with free-running stretches,
  // and drop stalls entirely once the quiet tail of the run starts.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 99) < 40) begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // Present one request and hold it until the transfer happens. An optional
  // idle burst comes first; valid never looks at stall to decide it.
  task automatic send_request(input logic [1:0] opc, input logic [31:0] dl,
                              input logic pf, input logic [31:0] per,
                              input logic [31:0] tgt, input logic [31:0] now);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= opc;
    deadline  <= dl;
    periodic  <= pf;
    period    <= per;
    target_id <= tgt;
    now_time  <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [31:0] clock_s;
    logic [31:0] dl;
    logic [31:0] per;
    logic [31:0] tgt;
    logic [31:0] now;
    logic        pf;
    int          issued;
    int          sent;
    int          pick;

    clock_s = '0;
    issued = 0;
    sent = 0;

    // Hold reset, then release it on a rising edge.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk. Ids are handed out from 1 in add order.
    // Tick an empty table: only the tick end comes back.
    send_request(OP_TICK, AllOnes, 1'b1, AllOnes, AllOnes, 32'd0);
    // Drop the unused op code.
    send_request(OpUnused, 32'h1234_5678, 1'b1, 32'h9ABC_DEF0, 32'd1, 32'd7);
    // Add one-shot at time zero (id 1), a periodic at the top of the range
    // with the widest period (id 2), a short periodic (id 3), a one-shot (id 4).
    send_request(OP_ADD, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    send_request(OP_ADD, AllOnes, 1'b1, AllOnes, AllOnes, AllOnes);
    send_request(OP_ADD, 32'd5, 1'b1, 32'd3, 32'd0, 32'd0);
    send_request(OP_ADD, 32'd10, 1'b0, 32'd0, 32'd0, 32'd0);
    // Cancel id 4, then cancel it again: an inactive match still counts.
    send_request(OP_CANCEL, 32'd0, 1'b0, 32'd0, 32'd4, 32'd0);
    send_request(OP_CANCEL, 32'd0, 1'b0, 32'd0, 32'd4, 32'd0);
    // Cancel ids that do not exist, at both ends of the range.
    send_request(OP_CANCEL, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    send_request(OP_CANCEL, 32'd0, 1'b0, 32'd0, AllOnes, 32'd0);
    // Fire and remove the one-shot at time zero.
    send_request(OP_TICK, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    // The short periodic fires once per tick even when the move stays due.
    send_request(OP_TICK, 32'd0, 1'b0, 32'd0, 32'd0, 32'd8);
    send_request(OP_TICK, 32'd0, 1'b0, 32'd0, 32'd0, 32'd8);
    // Top of time: the wide periodic fires and its deadline wraps.
    send_request(OP_TICK, 32'd0, 1'b0, 32'd0, 32'd0, AllOnes);
    // Periodic with zero period stays due on every tick (id 5).
    send_request(OP_ADD, 32'd0, 1'b1, 32'd0, 32'd0, 32'd0);
    send_request(OP_TICK, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    send_request(OpUnused, AllOnes, 1'b1, AllOnes, AllOnes, AllOnes);
    // Deadline at the sign boundary must compare unsigned (id 6).
    send_request(OP_ADD, 32'h8000_0000, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'd0);
    send_request(OP_TICK, 32'd0, 1'b0, 32'd0, 32'd0, 32'h7FFF_FFFF);
    // Cancel a periodic; it must stop firing but keep its slot.
    send_request(OP_CANCEL, 32'd0, 1'b0, 32'd0, 32'd5, 32'd0);
    send_request(OP_TICK, 32'd0, 1'b0, 32'd0, 32'd0, 32'h8000_0000);
    issued = 6;

    // Random mix around a moving clock. Cancelled and periodic entries never
    // leave, so the table fills up and full-table adds follow on their own.
    while (sent < RandomItems) begin
      if (sent == RandomItems - QuietItems) begin
        quiet <= 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        dl  = ($urandom_range(0, 9) == 0) ? $urandom : clock_s + $urandom_range(0, 200);
        pf  = ($urandom_range(0, 3) == 0);
        per = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 80);
        send_request(OP_ADD, dl, pf, per, $urandom, $urandom);
        issued++;
        sent++;
      end else if (pick < 65) begin
        tgt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, issued + 1);
        send_request(OP_CANCEL, $urandom, 1'($urandom_range(0, 1)), $urandom, tgt,
                     $urandom);
        sent++;
      end else if (pick < 95) begin
        clock_s = clock_s + $urandom_range(0, 60);
        now = ($urandom_range(0, 9) == 0) ? $urandom : clock_s;
        send_request(OP_TICK, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom,
                     now);
        sent++;
      end else begin
        send_request(OpUnused, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom,
                     $urandom);
      end
    end

    // Drop valid, let the checker register the last transfer, then wait for
    // every reply and a short drain.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ptt_pkg.sv
rtl/periodic_timer_table_unit.sv
sim/ptt_result_checker.sv
sim/tb_top.sv
